FILE: rtl/twtl_pkg.sv
// Shared types, codes and constants of the text wave table loader.
package twtl_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_EOF  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Result kinds.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// Characters that the line parser looks for.
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam int         MAX_LINE_OK   = 7;
	localparam logic [3:0] PREFIX_MAX    = 4'd8;
	localparam logic [23:0] MAG_MAX      = 24'hFFFFFF;
	localparam logic [23:0] MAG_LIMIT    = 24'd1677720;
	localparam logic [23:0] MAG_SAT      = 24'd2048;
	localparam logic [15:0] SAMPLE_POS_MAX = 16'h7FFF;
	localparam logic [15:0] SAMPLE_NEG_MAX = 16'h8000;

	localparam int READ_INDEX_W = 12;
	localparam int DIV_STEPS    = READ_INDEX_W;
	localparam int DIV_CW       = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		PH_START,
		PH_SIGN,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_COMMIT,
		ST_DIV,
		ST_READ,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic [7:0]              char_byte;
		logic [READ_INDEX_W-1:0] read_index;
	} req_item_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [15:0] sample;
		logic [12:0]        loaded_count;
	} rsp_item_t;

	typedef struct packed {
		logic capture;
		logic take_byte;
		logic eof_finish;
		logic commit;
		logic div_start;
		logic div_step;
		logic mem_read;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       div_last;
		logic       out_free;
	} status_t;

endpackage

FILE: rtl/twtl_ram.sv
// Generic single-port-write, registered-read RAM.
module twtl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/twtl_ctrl.sv
// Controller state machine of the text wave table loader.
module twtl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  twtl_pkg::status_t status,
	output twtl_pkg::cmd_t    cmd,
	output logic              busy
);

	twtl_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twtl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b1;
		unique case (state_q)
			twtl_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nx    = twtl_pkg::ST_DISPATCH;
				end
			end
			twtl_pkg::ST_DISPATCH: begin
				unique case (status.op)
					twtl_pkg::OP_BYTE: begin
						cmd.take_byte = 1'b1;
						state_nx      = twtl_pkg::ST_IDLE;
					end
					twtl_pkg::OP_EOF: begin
						cmd.eof_finish = 1'b1;
						state_nx       = twtl_pkg::ST_COMMIT;
					end
					twtl_pkg::OP_READ: begin
						cmd.div_start = 1'b1;
						state_nx      = twtl_pkg::ST_DIV;
					end
					default: begin
						state_nx = twtl_pkg::ST_IDLE;
					end
				endcase
			end
			twtl_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nx   = twtl_pkg::ST_PUT;
			end
			twtl_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nx = twtl_pkg::ST_READ;
				end
			end
			twtl_pkg::ST_READ: begin
				cmd.mem_read = 1'b1;
				state_nx     = twtl_pkg::ST_PUT;
			end
			twtl_pkg::ST_PUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = twtl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = twtl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/twtl_datapath.sv
// Datapath: line parser, table store, modulo divider and output register.
module twtl_datapath #(
	parameter int TABLE_DEPTH = 4096,
	parameter int LINE_CHUNK  = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  twtl_pkg::req_item_t req,
	input  twtl_pkg::cmd_t      cmd,
	input  logic                rsp_stall,
	output twtl_pkg::status_t   status,
	output twtl_pkg::rsp_item_t rsp,
	output logic                rsp_valid
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = $clog2(LINE_CHUNK + 1);

	function automatic logic [15:0] sat16(input logic [23:0] mag, input logic neg);
		logic [15:0] v;
		v = {1'b0, mag[10:0], 4'b0000};
		if (mag >= twtl_pkg::MAG_SAT) begin
			return neg ? twtl_pkg::SAMPLE_NEG_MAX : twtl_pkg::SAMPLE_POS_MAX;
		end
		return neg ? (16'd0 - v) : v;
	endfunction

	twtl_pkg::req_item_t req_q;

	// Line parser state.
	logic [LW-1:0]     line_len_q;
	logic [3:0]        prefix_len_q;
	logic              prefix_open_q;
	twtl_pkg::phase_t  phase_q;
	logic              neg_q;
	logic [23:0]       mag_q;

	// Table bookkeeping.
	logic [CW-1:0] wr_cnt_q;
	logic [CW-1:0] committed_q;
	logic [CW-1:0] high_water_q;
	logic [CW-1:0] eof_cnt_q;
	logic          kind_q;

	// Divider.
	logic [CW-1:0]                     rem_q;
	logic [twtl_pkg::READ_INDEX_W-1:0] dvd_q;
	logic [twtl_pkg::DIV_CW-1:0]       step_q;
	logic                              hit_q;

	logic                       rsp_valid_q;
	twtl_pkg::rsp_item_t        rsp_q;

	logic [7:0]       c;
	logic             is_digit, is_minus, take, line_end, byte_ok, eof_ok;
	logic [LW-1:0]    len_nx;
	logic [3:0]       plen_nx;
	logic             open_nx, neg_nx;
	twtl_pkg::phase_t ph_nx;
	logic [23:0]      mag_nx, mag10;
	logic [3:0]       digit_val;
	logic             wr_en;
	logic [15:0]      wr_val;
	logic [CW:0]      trial;
	logic [CW-1:0]    rem_nx;
	logic [CW-1:0]    wr_cnt_inc;
	logic [15:0]      rdata;
	logic [31:0]      eof_wide;

	assign c = req_q.char_byte;

	always_comb begin
		is_digit  = (c >= twtl_pkg::CH_ZERO) && (c <= twtl_pkg::CH_NINE);
		is_minus  = (c == twtl_pkg::CH_MINUS);
		take      = prefix_open_q && (is_digit || is_minus) && (prefix_len_q < twtl_pkg::PREFIX_MAX);
		len_nx    = line_len_q + LW'(1);
		digit_val = 4'(c - twtl_pkg::CH_ZERO);
		mag10     = (mag_q << 3) + (mag_q << 1) + {20'd0, digit_val};
		plen_nx   = prefix_len_q;
		open_nx   = prefix_open_q;
		ph_nx     = phase_q;
		neg_nx    = neg_q;
		mag_nx    = mag_q;
		if (take) begin
			plen_nx = prefix_len_q + 4'd1;
			if (phase_q == twtl_pkg::PH_START && is_minus) begin
				neg_nx = 1'b1;
				ph_nx  = twtl_pkg::PH_SIGN;
			end else if (phase_q == twtl_pkg::PH_DONE) begin
				ph_nx = twtl_pkg::PH_DONE;
			end else if (!is_digit) begin
				ph_nx = twtl_pkg::PH_DONE;
			end else begin
				ph_nx  = twtl_pkg::PH_DIGITS;
				mag_nx = (mag_q > twtl_pkg::MAG_LIMIT) ? twtl_pkg::MAG_MAX : mag10;
			end
		end else begin
			open_nx = 1'b0;
		end
		line_end = (c == twtl_pkg::CH_NEWLINE) || (len_nx >= LW'(LINE_CHUNK));
		byte_ok  = (len_nx <= LW'(twtl_pkg::MAX_LINE_OK)) && (plen_nx != 4'd0);
		eof_ok   = (line_len_q != '0) && (line_len_q <= LW'(twtl_pkg::MAX_LINE_OK))
			&& (prefix_len_q != 4'd0);
		wr_en    = ((cmd.take_byte && line_end && byte_ok) || (cmd.eof_finish && eof_ok))
			&& (wr_cnt_q < CW'(TABLE_DEPTH));
		wr_val   = cmd.take_byte ? sat16(mag_nx, neg_nx) : sat16(mag_q, neg_q);
		wr_cnt_inc = wr_cnt_q + CW'(1);
	end

	// One bit of restoring division per cycle gives read_index mod committed count.
	always_comb begin
		trial = {rem_q, dvd_q[twtl_pkg::READ_INDEX_W-1]};
		if (trial >= {1'b0, committed_q}) begin
			rem_nx = CW'(trial - {1'b0, committed_q});
		end else begin
			rem_nx = trial[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			dvd_q  <= req_q.read_index;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_nx;
			dvd_q  <= dvd_q << 1;
			step_q <= step_q + twtl_pkg::DIV_CW'(1);
		end
		if (cmd.mem_read) begin
			hit_q <= rem_q < high_water_q;
		end
		if (cmd.out_load) begin
			rsp_q.result_kind <= kind_q;
			if (kind_q == twtl_pkg::KIND_READ) begin
				rsp_q.sample       <= hit_q ? rdata : 16'd0;
				rsp_q.loaded_count <= '0;
			end else begin
				rsp_q.sample       <= '0;
				rsp_q.loaded_count <= eof_wide[12:0];
			end
		end
	end

	assign eof_wide = 32'(eof_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q    <= '0;
			prefix_len_q  <= '0;
			prefix_open_q <= 1'b1;
			phase_q       <= twtl_pkg::PH_START;
			neg_q         <= 1'b0;
			mag_q         <= '0;
			wr_cnt_q      <= '0;
			committed_q   <= CW'(TABLE_DEPTH);
			high_water_q  <= '0;
			eof_cnt_q     <= '0;
			kind_q        <= twtl_pkg::KIND_LOAD;
			rsp_valid_q   <= 1'b0;
		end else begin
			if ((cmd.take_byte && line_end) || cmd.eof_finish) begin
				line_len_q    <= '0;
				prefix_len_q  <= '0;
				prefix_open_q <= 1'b1;
				phase_q       <= twtl_pkg::PH_START;
				neg_q         <= 1'b0;
				mag_q         <= '0;
			end else if (cmd.take_byte) begin
				line_len_q    <= len_nx;
				prefix_len_q  <= plen_nx;
				prefix_open_q <= open_nx;
				phase_q       <= ph_nx;
				neg_q         <= neg_nx;
				mag_q         <= mag_nx;
			end
			if (wr_en) begin
				wr_cnt_q <= wr_cnt_inc;
				if (wr_cnt_inc > high_water_q) begin
					high_water_q <= wr_cnt_inc;
				end
			end
			if (cmd.commit) begin
				if (wr_cnt_q != '0) begin
					committed_q <= wr_cnt_q;
				end
				wr_cnt_q  <= '0;
				eof_cnt_q <= wr_cnt_q;
				kind_q    <= twtl_pkg::KIND_LOAD;
			end
			if (cmd.div_start) begin
				kind_q <= twtl_pkg::KIND_READ;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	twtl_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_cnt_q[AW-1:0]),
		.wdata(wr_val),
		.re   (cmd.mem_read),
		.raddr(rem_q[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		status.op       = req_q.operation;
		status.div_last = (step_q == twtl_pkg::DIV_CW'(twtl_pkg::DIV_STEPS - 1));
		status.out_free = !rsp_valid_q || !rsp_stall;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: rtl/text_wave_table_loader_core.sv
// Top level of the text wave table loader: controller, datapath and checks.
//
// The block reads a text file one byte per item, cuts it into lines (a line
// ends after a newline or after LINE_CHUNK bytes) and stores the value of every
// short numeric line, times sixteen and saturated to 16 bits signed, in the
// next entry of a TABLE_DEPTH-entry wave table. An end-of-file item commits the
// number of entries loaded, if there were any, and returns that count; a read
// item returns the entry at read_index modulo the committed count, so a short
// table repeats over the whole index range. Items are taken one at a time: a
// text byte passes through the dispatch state, an end-of-file item through
// dispatch, commit and output, and a read item through dispatch, the
// restoring divider that resolves one bit of the 12-bit index per cycle, a
// registered table read and output. A finished result waits in the output
// register, and the block goes on taking items while it waits unless a
// second result is due. Table entries that no load has ever reached read as
// zero, which a high-water count provides, so the block needs no clearing
// pass after reset.
module text_wave_table_loader_core #(
	parameter int TABLE_DEPTH = 4096,
	parameter int LINE_CHUNK  = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  twtl_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output twtl_pkg::rsp_item_t rsp
);

	twtl_pkg::cmd_t    cmd;
	twtl_pkg::status_t status;
	logic              busy;

	// The controller sequences each item; all arithmetic and storage sit in the datapath.
	twtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	twtl_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.LINE_CHUNK (LINE_CHUNK)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.rsp_stall(rsp_stall),
		.status   (status),
		.rsp      (rsp),
		.rsp_valid(rsp_valid)
	);

	// The block stalls new items whenever it is working on one.
	assign req_stall = busy;

	// At most one datapath command is issued in any cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	// A result is never loaded over one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid || !rsp_stall))
		else $error("result loaded over a pending one");

	// An accepted item keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("item accepted while the previous one is unfinished");

	// Each result kind carries zero in the field that belongs to the other kind.
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.result_kind == twtl_pkg::KIND_LOAD && rsp.sample == 16'sd0)
			|| (rsp.result_kind == twtl_pkg::KIND_READ && rsp.loaded_count == 13'd0)))
		else $error("result field does not match its kind");

endmodule

FILE: tb/wave_load_checker.sv
// Checker for the text wave table loader: watches both channels, predicts and compares results.
`timescale 1ns / 100ps

module wave_load_checker
	import twtl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  req_item_t  req,
	input  logic       rsp_valid,
	input  logic       rsp_stall,
	input  rsp_item_t  rsp,
	output int         fail_count,
	output int         pending
);

	localparam int TABLE_DEPTH = 4096;
	localparam int LINE_CHUNK  = 255;

	// Shadow of the wave table and of the line parser.
	logic signed [15:0] wave_mem [TABLE_DEPTH];
	int unsigned        fill_cnt;
	int unsigned        live_cnt;
	int unsigned        line_len;
	int unsigned        run_len;
	bit                 run_open;
	bit                 minus_seen;
	phase_t             conv_ph;
	logic [23:0]        mag;

	rsp_item_t          expected_rsp [$];
	rsp_item_t          want;
	int                 errs = 0;

	function automatic void clear_line_state();
		line_len   = 0;
		run_len    = 0;
		run_open   = 1'b1;
		conv_ph    = PH_START;
		minus_seen = 1'b0;
		mag        = '0;
	endfunction

	// Signed decimal conversion of the leading run, one character at a time.
	function automatic void feed_number(logic [7:0] c);
		bit is_digit;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (conv_ph == PH_START && c == CH_MINUS) begin
			minus_seen = 1'b1;
			conv_ph    = PH_SIGN;
			return;
		end
		if (conv_ph == PH_DONE)
			return;
		if (!is_digit) begin
			conv_ph = PH_DONE;
			return;
		end
		conv_ph = PH_DIGITS;
		if (mag > (MAG_MAX - 24'd9) / 24'd10)
			mag = MAG_MAX;
		else
			mag = mag * 24'd10 + 24'(c - CH_ZERO);
	endfunction

	function automatic void close_line();
		longint v;
		if (line_len >= 1 && line_len <= MAX_LINE_OK && run_len > 0) begin
			v = longint'(mag) * 16;
			if (minus_seen)
				v = -v;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			if (fill_cnt < TABLE_DEPTH) begin
				wave_mem[fill_cnt] = v[15:0];
				fill_cnt++;
			end
		end
		clear_line_state();
	endfunction

	function automatic void take_char(logic [7:0] c);
		line_len++;
		if (run_open && (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE))
				&& run_len < PREFIX_MAX)
		begin
			run_len++;
			feed_number(c);
		end else begin
			run_open = 1'b0;
		end
		if (c == CH_NEWLINE || line_len >= LINE_CHUNK)
			close_line();
	endfunction

	function automatic void predict_item(req_item_t it);
		rsp_item_t   r;
		int unsigned n;
		int unsigned span;
		case (it.operation)
			OP_BYTE: take_char(it.char_byte);
			OP_EOF: begin
				if (line_len > 0)
					close_line();
				n = fill_cnt;
				if (n != 0)
					live_cnt = n;
				fill_cnt = 0;
				r.result_kind  = KIND_LOAD;
				r.sample       = '0;
				r.loaded_count = n[12:0];
				expected_rsp.push_back(r);
			end
			OP_READ: begin
				span = live_cnt;
				if (span == 0 || span > TABLE_DEPTH)
					span = TABLE_DEPTH;
				r.result_kind  = KIND_READ;
				r.sample       = wave_mem[it.read_index % span];
				r.loaded_count = '0;
				expected_rsp.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic void note_failure(string what, rsp_item_t exp_r, rsp_item_t got);
		errs++;
		if (errs <= 10)
			$display("%0t %s: expected kind/sample/count %0d/%0d/%0d, got %0d/%0d/%0d",
				$time, what, exp_r.result_kind, exp_r.sample, exp_r.loaded_count,
				got.result_kind, got.sample, got.loaded_count);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++)
				wave_mem[k] = '0;
			fill_cnt = 0;
			live_cnt = TABLE_DEPTH;
			clear_line_state();
			expected_rsp.delete();
		end else begin
			// Results are checked before the item of this edge is predicted; the
			// result leaving now always belongs to an older item.
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					note_failure("result with none expected", '0, rsp);
				end else begin
					want = expected_rsp.pop_front();
					if (want.result_kind !== rsp.result_kind || want.sample !== rsp.sample
							|| want.loaded_count !== rsp.loaded_count)
						note_failure("result mismatch", want, rsp);
				end
			end
			if (req_valid && !req_stall)
				predict_item(req);
		end
		pending    <= expected_rsp.size();
		fail_count <= errs;
	end

endmodule

FILE: tb/tb.sv
// Testbench top for the text wave table loader: stimulus, response stalls and verdict.
`timescale 1ns / 100ps

module tb;
	import twtl_pkg::*;

	// The fourth operation code is unused by the block and must be ignored.
	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         FULL_LINES  = 40;
	localparam int         RAND_ITEMS  = 1100;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      rsp_stall = 1'b0;
	req_item_t req       = '0;
	logic      req_stall;
	logic      rsp_valid;
	rsp_item_t rsp;

	int         fail_count;
	int         pending;
	int         sent = 0;
	bit         quiet = 1'b0;
	logic [7:0] line_bytes [$];

	initial begin
		forever #5 clk = ~clk;
	end

	text_wave_table_loader_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	wave_load_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// The result side stalls at random, with a chance of 13 in a hundred, except
	// during the quiet stretch, when it takes every result at once.
	always @(posedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(99) < 13);
	end

	// Watchdog: a correct run finishes far inside this many cycles.
	initial begin
		for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++)
			@(posedge clk);
		$display("text_wave_table_loader_core test failed");
		$finish;
	end

	// Offers one item and waits for it to be taken. Random idle cycles are put
	// in front of it, so that gaps fall on every stage of the block's work.
	task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
			input logic [11:0] idx);
		req_item_t it;
		it.operation  = op;
		it.char_byte  = ch;
		it.read_index = idx;
		while (!quiet && $urandom_range(99) < 13) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do
			@(posedge clk);
		while (req_stall);
		sent++;
	endtask

	task automatic send_byte(input logic [7:0] ch);
		send_item(OP_BYTE, ch, 12'($urandom));
	endtask

	task automatic send_read(input logic [11:0] idx);
		send_item(OP_READ, 8'($urandom), idx);
	endtask

	task automatic send_eof();
		send_item(OP_EOF, 8'($urandom), 12'($urandom));
	endtask

	// Sends the line that has been built up, byte by byte, and empties it.
	task automatic send_line();
		while (line_bytes.size() != 0)
			send_byte(line_bytes.pop_front());
	endtask

	// Stops offering items until every result that is owed has been taken.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	// Builds one random line. Most are well-formed numbers of up to seven
	// bytes so that entries really get written; the rest are lines that are
	// too long, numbers followed by junk, raw noise including zero bytes and
	// newlines, odd sign patterns and the odd line of more than a chunk.
	// Returns 1 when the line is left without a newline for end of file.
	function automatic bit build_line();
		int         kind;
		int         n;
		bit         open_end;
		logic [7:0] b;
		open_end = 1'b0;
		kind = $urandom_range(99);
		if (kind < 55) begin
			if ($urandom_range(2) == 0)
				line_bytes.push_back(CH_MINUS);
			n = $urandom_range(1, 5);
			repeat (n) line_bytes.push_back(rand_digit());
			line_bytes.push_back(CH_NEWLINE);
		end else if (kind < 62) begin
			// Many bytes: most such lines are too long, and the run counter and the magnitude may saturate.
			if ($urandom_range(1))
				line_bytes.push_back(CH_MINUS);
			n = $urandom_range(6, 10);
			repeat (n) line_bytes.push_back(($urandom_range(2) == 0) ? CH_NINE : rand_digit());
			line_bytes.push_back(CH_NEWLINE);
		end else if (kind < 72) begin
			n = $urandom_range(1, 3);
			repeat (n) line_bytes.push_back(rand_digit());
			line_bytes.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom));
			if ($urandom_range(1))
				line_bytes.push_back(8'($urandom));
			line_bytes.push_back(CH_NEWLINE);
		end else if (kind < 84) begin
			n = $urandom_range(1, 10);
			repeat (n) line_bytes.push_back(8'($urandom));
			if ($urandom_range(1))
				line_bytes.push_back(CH_NEWLINE);
		end else if (kind < 92) begin
			case ($urandom_range(3))
				0: line_bytes.push_back(CH_MINUS);
				1: begin
					line_bytes.push_back(CH_MINUS);
					line_bytes.push_back(CH_MINUS);
					line_bytes.push_back(rand_digit());
				end
				2: begin
					line_bytes.push_back(CH_MINUS);
					line_bytes.push_back(rand_digit());
					line_bytes.push_back(CH_MINUS);
					line_bytes.push_back(rand_digit());
				end
				default: ;
			endcase
			line_bytes.push_back(CH_NEWLINE);
		end else if (kind < 98) begin
			// Last line of the file with no newline after it.
			if ($urandom_range(1))
				line_bytes.push_back(CH_MINUS);
			n = $urandom_range(1, 4);
			repeat (n) line_bytes.push_back(rand_digit());
			open_end = 1'b1;
		end else begin
			// A line longer than one chunk is cut after 255 bytes; the tail
			// becomes a line of its own.
			line_bytes.push_back(rand_digit());
			n = $urandom_range(254, 300);
			repeat (n) begin
				b = 8'($urandom);
				line_bytes.push_back((b == CH_NEWLINE) ? CH_SPACE : b);
			end
			line_bytes.push_back(CH_NEWLINE);
		end
		return open_end;
	endfunction

	initial begin
		int start;
		int r;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The unused operation, reads of the untouched table at
		// both ends of the index range and an empty load come first.
		send_item(OP_SPARE, 8'hFF, 12'hFFF);
		send_read(12'd0);
		send_read(12'hFFF);
		send_eof();
		// Positive and negative saturation, a bare minus and a final line
		// without newline; the load ends with four entries.
		line_bytes = '{8'h32, 8'h30, 8'h34, 8'h38, CH_NEWLINE};
		send_line();
		line_bytes = '{CH_MINUS, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NEWLINE};
		send_line();
		line_bytes = '{CH_MINUS, CH_NEWLINE};
		send_line();
		send_byte(8'h37);
		send_eof();
		send_read(12'hFFF);
		send_read(12'd1);
		send_read(12'd2);

		// A longer load. Reads in the middle see new entries through the
		// previous, short count.
		for (int k = 0; k < FULL_LINES; k++) begin
			if ($urandom_range(3) == 0)
				line_bytes.push_back(CH_MINUS);
			line_bytes.push_back(rand_digit());
			line_bytes.push_back(CH_NEWLINE);
			send_line();
			if (k % 20 == 10)
				send_read(12'($urandom_range(4095)));
		end
		send_eof();
		// The sender holds off here until every result has been returned.
		wait_drained();
		repeat (4) send_read(12'($urandom_range(4095)));

		// Random files with reads, stray operations and ends of file mixed in.
		start = sent;
		while (sent - start < RAND_ITEMS) begin
			quiet <= (sent - start >= 400) && (sent - start < 650);
			if (build_line()) begin
				send_line();
				send_eof();
			end else begin
				send_line();
				r = $urandom_range(99);
				if (r < 25)
					repeat ($urandom_range(1, 3)) send_read(12'($urandom_range(4095)));
				else if (r < 31)
					send_eof();
				else if (r < 33)
					send_item(OP_SPARE, 8'($urandom), 12'($urandom));
			end
		end
		quiet <= 1'b0;
		send_eof();

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("text_wave_table_loader_core test passed");
		else
			$display("text_wave_table_loader_core test failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/twtl_pkg.sv
rtl/twtl_ram.sv
rtl/twtl_ctrl.sv
rtl/twtl_datapath.sv
rtl/text_wave_table_loader_core.sv
tb/wave_load_checker.sv
tb/tb.sv
